@@ design/cfba_pkg.sv @@
// shared constants, codes and types for the chunked fixed-block allocator
// no dependencies; imported by the allocator core

package cfba_pkg;

  // default chunk limit and fixed geometry of the link store
  localparam int CFBA_MAX_CHUNKS = 16;
  localparam int CHUNK_SLOTS     = 16;
  localparam int LINKS_PER_CHUNK = 256;

  // field widths
  localparam int CHUNK_W  = 4;
  localparam int BLOCK_W  = 8;
  localparam int BSIZE_W  = 9;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;

  // configuration register reset values and block size clamp
  localparam logic [BLOCK_W-1:0] BPC_RESET   = 8'd255;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 9'd64;
  localparam logic [BSIZE_W-1:0] BSIZE_MAX   = 9'd256;

  // request kinds carried on in_tuser
  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  // result status carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED        = 2'd0,
    STAT_OUT_OF_CHUNKS  = 2'd1,
    STAT_RELEASED       = 2'd2,
    STAT_BAD_RELEASE    = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic {
    REG_BLOCKS_PER_CHUNK = 1'b0,
    REG_BLOCK_SIZE       = 1'b1
  } cfg_reg_t;

endpackage

@@ design/chunked_fixed_block_allocator_core.sv @@
// fixed-size block allocator over a bounded set of chunks, single-item sequencer
// release: S_RCHK checks and pushes, then S_FIN; allocate from the current chunk: S_ACHK,
//   S_ADONE, S_FIN; else S_SCAN walks the open chunks in order, and if none has a free block
//   S_INIT opens a new chunk, one link per block, then S_AREAD and S_ADONE; out of chunks, S_FIN
// throughput: one request at a time; the link store port and the chunk sequencer set the pace
// reset (rst_n low, synchronous): no chunks open, no current chunk, all free lists empty;
//   the link store itself is not cleared, each chunk's links are written when it opens
// depends on cfba_pkg

module chunked_fixed_block_allocator_core
  import cfba_pkg::*;
#(
  parameter int MAX_CHUNKS = CFBA_MAX_CHUNKS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] release_chunk, [11:4] release_block, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] grant_chunk, [11:4] grant_block,
                                  // [27:12] grant_offset, [31:28] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // usable chunk slots: the parameter, capped by the 4-bit chunk number
  localparam int CAP = (MAX_CHUNKS < CHUNK_SLOTS) ? MAX_CHUNKS : CHUNK_SLOTS;
  // chunk index width, and counter width that can also hold CAP itself
  localparam int CIW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);
  // link store address: chunk index above block index
  localparam int AW  = CIW + BLOCK_W;
  localparam int MEM_DEPTH = CAP * LINKS_PER_CHUNK;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_ACHK,   // allocate: test current chunk, link read issued speculatively
    S_SCAN,   // allocate: walk open chunks for the first one with a free block
    S_INIT,   // allocate: write links k -> k+1 of a newly opened chunk
    S_AREAD,  // allocate: read head link of the fresh chunk
    S_ADONE,  // allocate: link data back, pop the head
    S_RCHK,   // release: check and push
    S_FIN     // hand the result to the output register
  } state_t;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [BLOCK_W-1:0]   bpc_r, bpc_nxt;          // blocks per chunk
  logic [BSIZE_W-1:0]   bsize_r, bsize_nxt;      // bytes per block
  logic [BLOCK_W-1:0]   free_head_r  [CAP];
  logic [BLOCK_W-1:0]   free_head_nxt[CAP];
  logic [BLOCK_W-1:0]   free_count_r  [CAP];
  logic [BLOCK_W-1:0]   free_count_nxt[CAP];
  logic [CW-1:0]        chunks_open_r, chunks_open_nxt;
  logic [CIW-1:0]       current_chunk_r, current_chunk_nxt;
  logic                 current_valid_r, current_valid_nxt;

  // working registers of the sequencer
  logic [CW-1:0]        cidx_r, cidx_nxt;        // chunk under work / scan pointer
  logic [BLOCK_W-1:0]   kcnt_r, kcnt_nxt;        // link init counter
  logic [CHUNK_W-1:0]   rel_chunk_r, rel_chunk_nxt;
  logic [BLOCK_W-1:0]   rel_block_r, rel_block_nxt;

  // pending result, then the output register
  status_t              res_status_r, res_status_nxt;
  logic [CHUNK_W-1:0]   res_chunk_r, res_chunk_nxt;
  logic [BLOCK_W-1:0]   res_block_r, res_block_nxt;
  logic [OFFSET_W-1:0]  res_offset_r, res_offset_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [31:0]          out_data_r, out_data_nxt;

  // link store port
  logic [BLOCK_W-1:0]   link_mem [MEM_DEPTH];
  logic [BLOCK_W-1:0]   link_rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [BLOCK_W-1:0]   mem_wdata;
  logic [AW-1:0]        rd_addr;

  // ---------------------------------------------------------------------------
  // shared datapath: one chunk slot selected by cidx_r
  // ---------------------------------------------------------------------------
  logic [CIW-1:0]       csel;
  logic [BLOCK_W-1:0]   fh;                      // head of the selected chunk
  logic [BLOCK_W-1:0]   fc;                      // free count of the selected chunk
  logic [BSIZE_W-1:0]   bs_clamped;
  logic [16:0]          offset_prod;
  logic                 rel_bad;

  assign csel       = cidx_r[CIW-1:0];
  assign fh         = free_head_r[csel];
  assign fc         = free_count_r[csel];
  // the head link of the selected chunk is always being read
  assign rd_addr    = {csel, fh};
  assign bs_clamped = (bsize_r > BSIZE_MAX) ? BSIZE_MAX : bsize_r;
  assign offset_prod = 17'(fh) * 17'(bs_clamped);

  // release must name an open chunk, a block in range, and a chunk not already full
  assign rel_bad = (rel_chunk_r >= chunks_open_r) || (rel_block_r >= bpc_r) || (fc >= bpc_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt         = state_r;
    bpc_nxt           = bpc_r;
    bsize_nxt         = bsize_r;
    free_head_nxt     = free_head_r;
    free_count_nxt    = free_count_r;
    chunks_open_nxt   = chunks_open_r;
    current_chunk_nxt = current_chunk_r;
    current_valid_nxt = current_valid_r;
    cidx_nxt          = cidx_r;
    kcnt_nxt          = kcnt_r;
    rel_chunk_nxt     = rel_chunk_r;
    rel_block_nxt     = rel_block_r;
    res_status_nxt    = res_status_r;
    res_chunk_nxt     = res_chunk_r;
    res_block_nxt     = res_block_r;
    res_offset_nxt    = res_offset_r;
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_data_nxt      = out_data_r;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;

    // configuration transfer, only while idle
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCKS_PER_CHUNK: bpc_nxt = cfg_data[BLOCK_W-1:0];
        REG_BLOCK_SIZE:       bsize_nxt = cfg_data;
        default: ;
      endcase
    end

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rel_chunk_nxt = in_tdata[3:0];
          rel_block_nxt = in_tdata[11:4];
          if (mode_t'(in_tuser[0]) == MODE_RELEASE) begin
            cidx_nxt  = CW'(in_tdata[3:0]);
            state_nxt = S_RCHK;
          end else begin
            cidx_nxt  = CW'(current_chunk_r);
            state_nxt = S_ACHK;
          end
        end
      end

      S_ACHK: begin
        if (current_valid_r && (fc != '0)) begin
          // head link read issued this cycle
          state_nxt = S_ADONE;
        end else begin
          cidx_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (cidx_r < chunks_open_r) begin
          if (fc != '0) begin
            current_chunk_nxt = csel;
            current_valid_nxt = 1'b1;
            state_nxt         = S_ADONE;
          end else begin
            cidx_nxt = cidx_r + CW'(1);
          end
        end else if ((chunks_open_r == CW'(CAP)) || (bpc_r == '0)) begin
          res_status_nxt = STAT_OUT_OF_CHUNKS;
          res_chunk_nxt  = '0;
          res_block_nxt  = '0;
          res_offset_nxt = '0;
          state_nxt      = S_FIN;
        end else begin
          // cidx_r already names the next unopened chunk
          kcnt_nxt  = '0;
          state_nxt = S_INIT;
        end
      end

      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = {csel, kcnt_r};
        mem_wdata = kcnt_r + 8'd1;
        if (kcnt_r == bpc_r - 8'd1) begin
          free_head_nxt[csel]  = '0;
          free_count_nxt[csel] = bpc_r;
          chunks_open_nxt      = chunks_open_r + CW'(1);
          current_chunk_nxt    = csel;
          current_valid_nxt    = 1'b1;
          state_nxt            = S_AREAD;
        end else begin
          kcnt_nxt = kcnt_r + 8'd1;
        end
      end

      S_AREAD: begin
        state_nxt = S_ADONE;
      end

      S_ADONE: begin
        free_head_nxt[csel]  = link_rdata_r;
        free_count_nxt[csel] = fc - 8'd1;
        res_status_nxt       = STAT_GRANTED;
        res_chunk_nxt        = CHUNK_W'(cidx_r);
        res_block_nxt        = fh;
        res_offset_nxt       = offset_prod[OFFSET_W-1:0];
        state_nxt            = S_FIN;
      end

      S_RCHK: begin
        res_chunk_nxt  = '0;
        res_block_nxt  = '0;
        res_offset_nxt = '0;
        if (rel_bad) begin
          res_status_nxt = STAT_BAD_RELEASE;
        end else begin
          // push: released block links to the old head
          mem_we               = 1'b1;
          mem_waddr            = {csel, rel_block_r};
          mem_wdata            = fh;
          free_head_nxt[csel]  = rel_block_r;
          free_count_nxt[csel] = fc + 8'd1;
          res_status_nxt       = STAT_RELEASED;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {4'd0, res_offset_r, res_block_r, res_chunk_r};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      bpc_r           <= BPC_RESET;
      bsize_r         <= BSIZE_RESET;
      for (int i = 0; i < CAP; i++) begin
        free_head_r[i]  <= '0;
        free_count_r[i] <= '0;
      end
      chunks_open_r   <= '0;
      current_chunk_r <= '0;
      current_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      bpc_r           <= bpc_nxt;
      bsize_r         <= bsize_nxt;
      free_head_r     <= free_head_nxt;
      free_count_r    <= free_count_nxt;
      chunks_open_r   <= chunks_open_nxt;
      current_chunk_r <= current_chunk_nxt;
      current_valid_r <= current_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    // payload, no reset
    cidx_r       <= cidx_nxt;
    kcnt_r       <= kcnt_nxt;
    rel_chunk_r  <= rel_chunk_nxt;
    rel_block_r  <= rel_block_nxt;
    res_status_r <= res_status_nxt;
    res_chunk_r  <= res_chunk_nxt;
    res_block_r  <= res_block_nxt;
    res_offset_r <= res_offset_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // link store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rdata_r <= link_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // one request in flight: no new transfer right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // never more chunks open than slots
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_open_r <= CW'(CAP))
    else $error("open chunk count beyond capacity");

  // the current chunk is always an open one
  a_current_open: assert property (@(posedge clk) disable iff (!rst_n)
    current_valid_r |-> (CW'(current_chunk_r) < chunks_open_r))
    else $error("current chunk not open");

  // a pop never hits an empty chunk
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADONE) |-> (fc != '0))
    else $error("allocation from an empty chunk");

  // a finished chunk init leaves the new chunk fully free
  a_init_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT && state_nxt == S_AREAD) |=> (fc == bpc_r))
    else $error("new chunk free count mismatch");

endmodule
